@@ rtl/core/pcm_pkg.sv @@
package pcm_pkg;

  localparam int unsigned ChanW = 5;
  localparam int unsigned LayerW = 3;
  localparam int unsigned NumLayers = 6;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 15;
  localparam logic [ChanW-1:0] ChanMax = 5'd31;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] REG_LAYER_MASK = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_USE_SUB = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_MAIN_CLIP = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_SUB_CLIP = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_HALF = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_SUBTRACT = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_FIXED_COLOR = 3'd6;

  typedef enum logic [1:0] {
    MCLIP_ALWAYS_BLACK,
    MCLIP_BLACK_OUTSIDE,
    MCLIP_BLACK_INSIDE,
    MCLIP_NEVER_BLACK
  } main_clip_t;

  typedef enum logic [1:0] {
    SCLIP_NEVER,
    SCLIP_INSIDE,
    SCLIP_OUTSIDE,
    SCLIP_ALWAYS
  } sub_clip_t;

  typedef struct packed {
    logic [NumLayers-1:0] layer_enable_mask;
    logic                 use_subscreen;
    main_clip_t           main_clip_mode;
    sub_clip_t            sub_clip_mode;
    logic                 half_enable;
    logic                 subtract_mode;
    logic [ChanW-1:0]     fixed_red;
    logic [ChanW-1:0]     fixed_green;
    logic [ChanW-1:0]     fixed_blue;
  } cfg_t;

endpackage

@@ rtl/core/pixel_color_math_blend.sv @@
// Color math for one composited pixel per clock. An item is taken whenever start
// is high; busy is always low, so one pixel can enter in every cycle. Its result
// appears on out_red, out_green and out_blue with out_strobe high for one cycle,
// once the item has passed the input register and then the blend logic into the
// result register. The receiver cannot stall the block. Configuration registers
// are written through cfg_we, cfg_index and cfg_data and must only change while
// no item is in flight.
module pixel_color_math_blend (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [4:0]                   in_main_red,
  input  logic [4:0]                   in_main_green,
  input  logic [4:0]                   in_main_blue,
  input  logic [2:0]                   in_main_layer,
  input  logic                         in_sub_valid,
  input  logic [4:0]                   in_sub_red,
  input  logic [4:0]                   in_sub_green,
  input  logic [4:0]                   in_sub_blue,
  input  logic                         in_window_active,
  output logic                         out_strobe,
  output logic [4:0]                   out_red,
  output logic [4:0]                   out_green,
  output logic [4:0]                   out_blue,
  input  logic                         cfg_we,
  input  logic [pcm_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [pcm_pkg::CfgDataW-1:0] cfg_data
);

  pcm_pkg::cfg_t cfg;

  logic                         accept;
  logic                         in_vld_r;
  logic [pcm_pkg::ChanW-1:0]    main_red_r;
  logic [pcm_pkg::ChanW-1:0]    main_green_r;
  logic [pcm_pkg::ChanW-1:0]    main_blue_r;
  logic [pcm_pkg::LayerW-1:0]   main_layer_r;
  logic                         sub_valid_r;
  logic [pcm_pkg::ChanW-1:0]    sub_red_r;
  logic [pcm_pkg::ChanW-1:0]    sub_green_r;
  logic [pcm_pkg::ChanW-1:0]    sub_blue_r;
  logic                         window_r;

  logic [7:0]                   mask_ext;
  logic                         layer_en;
  logic                         force_black;
  logic                         pass_main;
  logic                         use_sub;
  logic [pcm_pkg::ChanW-1:0]    op_red;
  logic [pcm_pkg::ChanW-1:0]    op_green;
  logic [pcm_pkg::ChanW-1:0]    op_blue;
  logic [pcm_pkg::ChanW-1:0]    blend_red;
  logic [pcm_pkg::ChanW-1:0]    blend_green;
  logic [pcm_pkg::ChanW-1:0]    blend_blue;

  logic                         out_vld_r;
  logic [pcm_pkg::ChanW-1:0]    red_r;
  logic [pcm_pkg::ChanW-1:0]    green_r;
  logic [pcm_pkg::ChanW-1:0]    blue_r;
  logic [pcm_pkg::ChanW-1:0]    red_nxt;
  logic [pcm_pkg::ChanW-1:0]    green_nxt;
  logic [pcm_pkg::ChanW-1:0]    blue_nxt;

  pcm_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      main_red_r   <= in_main_red;
      main_green_r <= in_main_green;
      main_blue_r  <= in_main_blue;
      main_layer_r <= in_main_layer;
      sub_valid_r  <= in_sub_valid;
      sub_red_r    <= in_sub_red;
      sub_green_r  <= in_sub_green;
      sub_blue_r   <= in_sub_blue;
      window_r     <= in_window_active;
    end
  end

  // Layers six and seven have no mask bit and never take part in color math.
  assign mask_ext = {2'b00, cfg.layer_enable_mask};
  assign layer_en = mask_ext[main_layer_r];

  always_comb begin
    force_black = 1'b0;
    pass_main   = 1'b0;
    if (!layer_en) begin
      pass_main = 1'b1;
    end else begin
      case (cfg.main_clip_mode)
        pcm_pkg::MCLIP_ALWAYS_BLACK:  force_black = 1'b1;
        pcm_pkg::MCLIP_BLACK_OUTSIDE: force_black = !window_r;
        pcm_pkg::MCLIP_BLACK_INSIDE:  force_black = window_r;
        default:                      force_black = 1'b0;
      endcase
      if (!force_black) begin
        case (cfg.sub_clip_mode)
          pcm_pkg::SCLIP_NEVER:   pass_main = 1'b1;
          pcm_pkg::SCLIP_INSIDE:  pass_main = !window_r;
          pcm_pkg::SCLIP_OUTSIDE: pass_main = window_r;
          default:                pass_main = 1'b0;
        endcase
      end
    end
  end

  assign use_sub  = cfg.use_subscreen && sub_valid_r;
  assign op_red   = use_sub ? sub_red_r   : cfg.fixed_red;
  assign op_green = use_sub ? sub_green_r : cfg.fixed_green;
  assign op_blue  = use_sub ? sub_blue_r  : cfg.fixed_blue;

  pcm_chan u_chan_red (
    .main_val (main_red_r),
    .op_val   (op_red),
    .subtract (cfg.subtract_mode),
    .half     (cfg.half_enable),
    .result   (blend_red)
  );

  pcm_chan u_chan_green (
    .main_val (main_green_r),
    .op_val   (op_green),
    .subtract (cfg.subtract_mode),
    .half     (cfg.half_enable),
    .result   (blend_green)
  );

  pcm_chan u_chan_blue (
    .main_val (main_blue_r),
    .op_val   (op_blue),
    .subtract (cfg.subtract_mode),
    .half     (cfg.half_enable),
    .result   (blend_blue)
  );

  always_comb begin
    if (force_black) begin
      red_nxt   = '0;
      green_nxt = '0;
      blue_nxt  = '0;
    end else if (pass_main) begin
      red_nxt   = main_red_r;
      green_nxt = main_green_r;
      blue_nxt  = main_blue_r;
    end else begin
      red_nxt   = blend_red;
      green_nxt = blend_green;
      blue_nxt  = blend_blue;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_vld_r) begin
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
    end
  end

  assign out_strobe = out_vld_r;
  assign out_red    = red_r;
  assign out_green  = green_r;
  assign out_blue   = blue_r;

  a_stage_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld_r |=> out_strobe)
    else $error("item in the input register produced no result");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !in_vld_r |=> !out_strobe)
    else $error("result strobe without an item");

  a_black: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld_r && force_black |=> out_red == '0 && out_green == '0 && out_blue == '0)
    else $error("clipped pixel is not black");

  a_pass: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld_r && pass_main |=> out_red == $past(main_red_r) &&
      out_green == $past(main_green_r) && out_blue == $past(main_blue_r))
    else $error("passed pixel differs from main color");

endmodule

@@ rtl/core/pcm_cfg.sv @@
module pcm_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [pcm_pkg::CfgIdxW-1:0]      cfg_index,
  input  logic [pcm_pkg::CfgDataW-1:0]     cfg_data,
  output pcm_pkg::cfg_t                    cfg
);

  pcm_pkg::cfg_t cfg_r;
  pcm_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        pcm_pkg::REG_LAYER_MASK:
          cfg_nxt.layer_enable_mask = cfg_data[pcm_pkg::NumLayers-1:0];
        pcm_pkg::REG_USE_SUB:     cfg_nxt.use_subscreen = cfg_data[0];
        pcm_pkg::REG_MAIN_CLIP:   cfg_nxt.main_clip_mode = pcm_pkg::main_clip_t'(cfg_data[1:0]);
        pcm_pkg::REG_SUB_CLIP:    cfg_nxt.sub_clip_mode = pcm_pkg::sub_clip_t'(cfg_data[1:0]);
        pcm_pkg::REG_HALF:        cfg_nxt.half_enable = cfg_data[0];
        pcm_pkg::REG_SUBTRACT:    cfg_nxt.subtract_mode = cfg_data[0];
        pcm_pkg::REG_FIXED_COLOR: begin
          cfg_nxt.fixed_red   = cfg_data[4:0];
          cfg_nxt.fixed_green = cfg_data[9:5];
          cfg_nxt.fixed_blue  = cfg_data[14:10];
        end
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.layer_enable_mask <= '0;
      cfg_r.use_subscreen     <= 1'b0;
      cfg_r.main_clip_mode    <= pcm_pkg::MCLIP_NEVER_BLACK;
      cfg_r.sub_clip_mode     <= pcm_pkg::SCLIP_NEVER;
      cfg_r.half_enable       <= 1'b0;
      cfg_r.subtract_mode     <= 1'b0;
      cfg_r.fixed_red         <= '0;
      cfg_r.fixed_green       <= '0;
      cfg_r.fixed_blue        <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

@@ rtl/core/pcm_chan.sv @@
module pcm_chan (
  input  logic [pcm_pkg::ChanW-1:0] main_val,
  input  logic [pcm_pkg::ChanW-1:0] op_val,
  input  logic                      subtract,
  input  logic                      half,
  output logic [pcm_pkg::ChanW-1:0] result
);

  logic [pcm_pkg::ChanW:0] sum;
  logic [pcm_pkg::ChanW:0] diff;
  logic [pcm_pkg::ChanW:0] raw;
  logic [pcm_pkg::ChanW:0] scaled;

  always_comb begin
    sum  = {1'b0, main_val} + {1'b0, op_val};
    diff = {1'b0, main_val} - {1'b0, op_val};
    if (subtract) begin
      raw = (op_val >= main_val) ? '0 : diff;
    end else begin
      raw = sum;
    end
    scaled = half ? (raw >> 1) : raw;
    if (scaled > {1'b0, pcm_pkg::ChanMax}) begin
      result = pcm_pkg::ChanMax;
    end else begin
      result = scaled[pcm_pkg::ChanW-1:0];
    end
  end

endmodule
